/* rtl/url_form_pair_encoder_assert.svh */
// assertion macros used by the url form pair encoder rtl
`ifndef URL_FORM_PAIR_ENCODER_ASSERT_SVH
`define URL_FORM_PAIR_ENCODER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define UFPE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ufpe assertion failed");

// next-cycle implication, checked outside reset
`define UFPE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ufpe assertion failed");

`endif

/* rtl/ufpe_pkg.sv */
// shared types, constants and helper functions of the url form pair encoder
package ufpe_pkg;

    localparam int unsigned POS_WIDTH_DEFAULT = 16;
    localparam logic [15:0] BUFFER_LIMIT_RESET = 16'd1024;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_KEY   = 2'd1,
        OP_VALUE = 2'd2,
        OP_END   = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_DATA = 2'd0,
        ST_DONE = 2'd1,
        ST_FAIL = 2'd2
    } status_t;

    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_EQ    = 8'h3d;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UZ    = 8'h5a;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LZ    = 8'h7a;
    localparam logic [7:0] CH_DOT   = 8'h2e;
    localparam logic [7:0] CH_DASH  = 8'h2d;
    localparam logic [7:0] CH_UNDER = 8'h5f;
    localparam logic [3:0] HEX_ALPHA_START = 4'd10;

    // what one step of an item does
    typedef struct packed {
        logic [7:0] ch;          // character written by this step
        logic       writes;      // step performs a buffer write
        logic       final_step;  // last step of the item
    } step_info_t;

    function automatic logic is_plain(input logic [7:0] c);
        is_plain = (c >= CH_LA && c <= CH_LZ) || (c >= CH_UA && c <= CH_UZ) ||
                   (c >= CH_ZERO && c <= CH_NINE) ||
                   c == CH_DOT || c == CH_DASH || c == CH_UNDER;
    endfunction

    function automatic logic [7:0] hex_digit(input logic [3:0] n);
        if (n >= HEX_ALPHA_START)
            hex_digit = CH_UA + {4'd0, n - HEX_ALPHA_START};
        else
            hex_digit = CH_ZERO + {4'd0, n};
    endfunction

endpackage

/* rtl/ufpe_char_sel.sv */
// picks the character and step flags for one step of the held item
module ufpe_char_sel (
    input  ufpe_pkg::opcode_t    op,
    input  logic [7:0]           data_byte,
    input  logic                 prior_nonzero,
    input  logic [1:0]           step_idx,
    input  logic                 eq_needed,
    output ufpe_pkg::step_info_t info
);
    import ufpe_pkg::*;

    logic       plain;
    logic       space;
    logic [1:0] enc_last;
    logic [1:0] enc_idx;
    logic [7:0] enc_ch;

    always_comb
    begin
        plain    = is_plain(data_byte);
        space    = (data_byte == CH_SPACE);
        enc_last = (plain || space) ? 2'd0 : 2'd2;
        // value bytes that open the value shift the escape sequence by one for '='
        enc_idx  = (op == OP_VALUE && eq_needed) ? step_idx - 2'd1 : step_idx;

        if (plain)
            enc_ch = data_byte;
        else if (space)
            enc_ch = CH_PLUS;
        else if (enc_idx == 2'd0)
            enc_ch = CH_PCT;
        else if (enc_idx == 2'd1)
            enc_ch = hex_digit(data_byte[7:4]);
        else
            enc_ch = hex_digit(data_byte[3:0]);

        unique case (op)
            OP_START:
            begin
                info.ch         = CH_AMP;
                info.writes     = prior_nonzero;
                info.final_step = 1'b1;
            end
            OP_KEY:
            begin
                info.ch         = enc_ch;
                info.writes     = 1'b1;
                info.final_step = (step_idx == enc_last);
            end
            OP_VALUE:
            begin
                info.ch         = (eq_needed && step_idx == 2'd0) ? CH_EQ : enc_ch;
                info.writes     = 1'b1;
                info.final_step = (step_idx == enc_last + {1'b0, eq_needed});
            end
            OP_END:
            begin
                info.ch         = 8'd0;
                info.writes     = 1'b0;
                info.final_step = 1'b1;
            end
            default:
            begin
                info.ch         = 8'd0;
                info.writes     = 1'b0;
                info.final_step = 1'b1;
            end
        endcase
    end

endmodule

/* rtl/url_form_pair_encoder.sv */
// top level of the url form pair encoder: item register, step sequencer, result register
`include "url_form_pair_encoder_assert.svh"

// Appends one key=value pair, form-urlencoded, to a destination buffer of buffer_limit
// bytes. Send a start item (prior_length = bytes already in the buffer), then key and value
// bytes, then an end item. Each written character comes out as one transfer with its buffer
// position (status 0); the end item gives one transfer with the new length (status 1) or the
// offset to clear from (status 2). last marks the final transfer caused by an input item;
// items that cause nothing (start with zero length, bytes after the pair failed) give none.
// Timing: the output register takes one character per cycle while out_ready is high, and
// an item takes one step per character: start and end items finish in their first step, a key
// byte gives 1 or 3 characters, a value byte 1 to 4 (the first one carries '='). The next
// item is taken in the cycle the current one finishes its last step; each item passes
// through the item register and then the result register.
// buffer_limit may only be written while no pair traffic is in flight.
module url_form_pair_encoder #(
    parameter int unsigned POS_WIDTH = ufpe_pkg::POS_WIDTH_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    // input channel
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  opcode,
    input  logic [7:0]  data_byte,
    input  logic [15:0] prior_length,
    // result channel
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic [15:0] out_pos,
    output logic [1:0]  status,
    output logic        last
);
    import ufpe_pkg::*;

    // compare width: holds position + 1 and the 16-bit limit
    localparam int unsigned CMP_WIDTH = (POS_WIDTH + 1 > 16) ? POS_WIDTH + 1 : 16;

    // configuration
    logic [15:0]          buffer_limit_reg;

    // held input item
    logic                 item_valid_reg, item_valid_next;
    opcode_t              item_op_reg;
    logic [7:0]           item_byte_reg;
    logic [POS_WIDTH-1:0] item_prior_reg;
    logic                 item_prior_nz_reg;
    logic [1:0]           step_reg, step_next;
    logic                 eq_reg, eq_next;

    // pair state
    logic [POS_WIDTH-1:0] wp_reg, wp_next;
    logic [POS_WIDTH-1:0] pair_start_reg, pair_start_next;
    logic                 ovf_reg, ovf_next;
    logic                 key_seen_reg, key_seen_next;
    logic                 value_seen_reg, value_seen_next;

    // result register
    logic                 out_valid_reg, out_valid_next;
    logic [7:0]           out_byte_reg, out_byte_next;
    logic [15:0]          out_pos_reg, out_pos_next;
    status_t              out_status_reg, out_status_next;
    logic                 out_last_reg, out_last_next;

    // step datapath
    step_info_t           sel;
    logic                 accept;
    logic                 step_fire;
    logic                 eq_now;
    logic [POS_WIDTH-1:0] base_p;
    logic                 base_ovf;
    logic [CMP_WIDTH-1:0] p_ext;
    logic [CMP_WIDTH-1:0] next_ext;
    logic [CMP_WIDTH-1:0] lim_ext;
    logic                 do_write;
    logic                 emit_data;
    logic                 ovf_after;
    logic                 end_fail;
    logic                 load_out;

    // '=' is due only on the first value byte; decided at step 0 and held for the item
    assign eq_now = (step_reg == 2'd0) ? !value_seen_reg : eq_reg;

    ufpe_char_sel u_char_sel (
        .op            (item_op_reg),
        .data_byte     (item_byte_reg),
        .prior_nonzero (item_prior_nz_reg),
        .step_idx      (step_reg),
        .eq_needed     (eq_now),
        .info          (sel)
    );

    // a step advances whenever the result register is free or being drained
    assign step_fire = item_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !item_valid_reg || (step_fire && sel.final_step);
    assign accept    = in_valid && in_ready;

    always_comb
    begin
        // start item restarts the pair from prior_length before its '&'
        base_p    = (item_op_reg == OP_START) ? item_prior_reg : wp_reg;
        base_ovf  = (item_op_reg == OP_START) ? 1'b0 : ovf_reg;
        p_ext     = CMP_WIDTH'(base_p);
        next_ext  = p_ext + CMP_WIDTH'(1);
        lim_ext   = CMP_WIDTH'(buffer_limit_reg);
        // writes after failure are dropped without touching the position
        do_write  = sel.writes && !base_ovf;
        emit_data = do_write && (p_ext < lim_ext);
        ovf_after = base_ovf || (do_write && (next_ext >= lim_ext));
        end_fail  = ovf_reg || !key_seen_reg || !value_seen_reg;
        load_out  = step_fire && (emit_data || item_op_reg == OP_END);

        wp_next         = wp_reg;
        pair_start_next = pair_start_reg;
        ovf_next        = ovf_reg;
        key_seen_next   = key_seen_reg;
        value_seen_next = value_seen_reg;
        eq_next         = eq_reg;
        step_next       = step_reg;
        item_valid_next = item_valid_reg;

        if (step_fire)
        begin
            wp_next  = do_write ? base_p + POS_WIDTH'(1) : base_p;
            ovf_next = ovf_after;
            case (item_op_reg)
                OP_START:
                begin
                    pair_start_next = item_prior_reg;
                    key_seen_next   = 1'b0;
                    value_seen_next = 1'b0;
                end
                OP_KEY:
                begin
                    key_seen_next = 1'b1;
                end
                OP_VALUE:
                begin
                    value_seen_next = 1'b1;
                    eq_next         = eq_now;
                end
                default:
                begin
                    // end item leaves the pair state alone
                end
            endcase
            if (sel.final_step)
            begin
                step_next       = 2'd0;
                item_valid_next = 1'b0;
            end
            else
            begin
                step_next = step_reg + 2'd1;
            end
        end
        if (accept)
        begin
            item_valid_next = 1'b1;
            step_next       = 2'd0;
        end

        // result payload
        if (item_op_reg == OP_END)
        begin
            out_byte_next   = 8'd0;
            out_pos_next    = end_fail ? 16'(pair_start_reg) : 16'(wp_reg);
            out_status_next = end_fail ? ST_FAIL : ST_DONE;
            out_last_next   = 1'b1;
        end
        else
        begin
            out_byte_next   = sel.ch;
            out_pos_next    = 16'(base_p);
            out_status_next = ST_DATA;
            // a write that fails the pair is the last thing the item produces
            out_last_next   = sel.final_step || ovf_after;
        end

        if (load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buffer_limit_reg <= BUFFER_LIMIT_RESET;
            item_valid_reg   <= 1'b0;
            step_reg         <= 2'd0;
            eq_reg           <= 1'b0;
            wp_reg           <= '0;
            pair_start_reg   <= '0;
            ovf_reg          <= 1'b0;
            key_seen_reg     <= 1'b0;
            value_seen_reg   <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                buffer_limit_reg <= cfg_wr_data;
            item_valid_reg <= item_valid_next;
            step_reg       <= step_next;
            eq_reg         <= eq_next;
            wp_reg         <= wp_next;
            pair_start_reg <= pair_start_next;
            ovf_reg        <= ovf_next;
            key_seen_reg   <= key_seen_next;
            value_seen_reg <= value_seen_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_op_reg       <= opcode_t'(opcode);
            item_byte_reg     <= data_byte;
            item_prior_reg    <= POS_WIDTH'(prior_length);
            item_prior_nz_reg <= (POS_WIDTH'(prior_length) != '0);
        end
        if (load_out)
        begin
            out_byte_reg   <= out_byte_next;
            out_pos_reg    <= out_pos_next;
            out_status_reg <= out_status_next;
            out_last_reg   <= out_last_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_pos   = out_pos_reg;
    assign status    = out_status_reg;
    assign last      = out_last_reg;

    // only value bytes can run to a fourth step
    `UFPE_ASSERT_NOW(a_step_range, clk, rst_n,
        item_valid_reg && item_op_reg != OP_VALUE, step_reg != 2'd3)
    // completion and failure reports always close their item
    `UFPE_ASSERT_NOW(a_report_last, clk, rst_n,
        out_valid_reg && out_status_reg != ST_DATA, out_last_reg)
    // no character lands at or beyond the buffer size
    `UFPE_ASSERT_NEXT(a_data_in_buffer, clk, rst_n,
        load_out && item_op_reg != OP_END,
        out_valid_reg && out_status_reg == ST_DATA && out_pos_reg < buffer_limit_reg)
    // a new item is only taken when the held one is done
    `UFPE_ASSERT_NOW(a_take_when_done, clk, rst_n,
        in_ready && item_valid_reg, step_fire && sel.final_step)

endmodule
